// ===== src/sorted_list_engine_macros.svh =====
// assertion macros shared by the sorted list checks
`ifndef SORTED_LIST_ENGINE_MACROS_SVH
`define SORTED_LIST_ENGINE_MACROS_SVH

// same-cycle implication, clocked on clk_i and gated by rst_ni
`define SLE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted list check failed");

// next-cycle implication, clocked on clk_i and gated by rst_ni
`define SLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted list check failed");

`endif

// ===== src/sle_pkg.sv =====
// shared types and codes for the sorted list engine
package sle_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountOW = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic                     ins_en;
    logic                     del_en;
    logic signed [ValueW-1:0] value;
  } ctrl_t;

endpackage

// ===== src/sle_cell.sv =====
// one storage cell of the sorted chain
module sle_cell #(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx  = 0
) (
  input  logic                              clk_i,
  input  sle_pkg::ctrl_t                    ctrl_i,
  input  logic [CntW-1:0]                   count_i,
  input  logic signed [sle_pkg::ValueW-1:0] left_entry_i,
  input  logic                              left_gt_i,
  input  logic signed [sle_pkg::ValueW-1:0] right_entry_i,
  output logic signed [sle_pkg::ValueW-1:0] entry_o,
  output logic                              gt_o,
  output logic                              eq_o
);

  logic signed [sle_pkg::ValueW-1:0] entry_q, entry_d;
  logic                              valid;
  logic                              ge;

  assign valid = CntW'(Idx) < count_i;
  assign gt_o  = !valid || (entry_q > ctrl_i.value);
  assign eq_o  = valid && (entry_q == ctrl_i.value);
  assign ge    = valid && (entry_q >= ctrl_i.value);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en && gt_o) begin
      entry_d = left_gt_i ? left_entry_i : ctrl_i.value;
    end else if (ctrl_i.del_en && ge) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== src/sorted_list_engine.sv =====
// top level of the sorted list engine
// keeps up to CAPACITY signed 32-bit values in ascending order in a row of cells
// a request is taken at a rising edge with start_i high and busy_o low
// req_type_i selects insert, delete, lookup or clear; value_i is the operand
// busy_o stays low: every cell compares and shifts in the same cycle, so a new
// request may follow in every cycle
// the result is registered and appears in the cycle after the request, with done_o high for one cycle
// status_o, found_o, count_o, is_empty_o and is_full_o are valid only then
// found_o is taken over the stored values before the request; a clear reports no match
// the whole cell row and the count register are updated at the edge that takes the request;
// the found flag is an or over the equality flags of all cells
// insert into a full store returns full; delete of an absent value returns
// not found; both leave the store unchanged
// reset clears the count, so the store is empty; cell contents are not cleared
// the receiver cannot stall: each result must be taken in its strobe cycle
module sorted_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        req_type_i,
  input  logic signed [sle_pkg::ValueW-1:0] value_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic                              found_o,
  output logic [sle_pkg::CountOW-1:0]       count_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic signed [sle_pkg::ValueW-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]               gt_vec;
  logic [CAPACITY-1:0]               eq_vec;

  sle_pkg::req_e    req;
  sle_pkg::ctrl_t   ctrl;
  sle_pkg::status_e status_d;
  logic             found_any;
  logic             full;
  logic [CntW-1:0]  count_q, count_d;

  logic                         done_q;
  logic [1:0]                   status_q;
  logic                         found_q;
  logic [sle_pkg::CountOW-1:0]  res_count_q;
  logic                         empty_q;
  logic                         full_q;

  assign busy_o    = 1'b0;
  assign req       = sle_pkg::req_e'(req_type_i);
  assign found_any = |eq_vec;
  assign full      = count_q == CntW'(CAPACITY);

  assign ctrl.value  = value_i;
  assign ctrl.ins_en = start_i && (req == sle_pkg::REQ_INSERT) && !full;
  assign ctrl.del_en = start_i && (req == sle_pkg::REQ_DELETE) && found_any;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [sle_pkg::ValueW-1:0] left_entry;
    logic                              left_gt;
    logic signed [sle_pkg::ValueW-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_entry = value_i;
      assign left_gt    = 1'b0;
    end else begin : g_mid
      assign left_entry = entries[i-1];
      assign left_gt    = gt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    sle_cell #(
      .CntW (CntW),
      .Idx  (i)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .left_entry_i  (left_entry),
      .left_gt_i     (left_gt),
      .right_entry_i (right_entry),
      .entry_o       (entries[i]),
      .gt_o          (gt_vec[i]),
      .eq_o          (eq_vec[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = sle_pkg::STATUS_OK;
    if (start_i) begin
      unique case (req)
        sle_pkg::REQ_INSERT: begin
          if (full) begin
            status_d = sle_pkg::STATUS_FULL;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        sle_pkg::REQ_DELETE: begin
          if (!found_any) begin
            status_d = sle_pkg::STATUS_NOT_FOUND;
          end else begin
            count_d = count_q - CntW'(1);
          end
        end
        sle_pkg::REQ_LOOKUP: begin
          count_d = count_q;
        end
        sle_pkg::REQ_CLEAR: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      status_q    <= status_d;
      found_q     <= (req != sle_pkg::REQ_CLEAR) && found_any;
      res_count_q <= sle_pkg::CountOW'(count_d);
      empty_q     <= count_d == '0;
      full_q      <= count_d == CntW'(CAPACITY);
    end
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign found_o    = found_q;
  assign count_o    = res_count_q;
  assign is_empty_o = empty_q;
  assign is_full_o  = full_q;

endmodule

// ===== src/sle_checker.sv =====
// port-level checks for the sorted list engine, bound to the top level
`include "sorted_list_engine_macros.svh"

module sle_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              done_o,
  input logic [1:0]                        status_o,
  input logic                              found_o,
  input logic [sle_pkg::CountOW-1:0]       count_o,
  input logic                              is_empty_o,
  input logic                              is_full_o
);

  // every request gets its result in the next cycle
  `SLE_ASSERT_NEXT(a_req_done, start_i && !busy_o, done_o)
  // a result only follows a request
  `SLE_ASSERT_SAME(a_done_req, done_o, $past(start_i && !busy_o))
  // empty store shows a zero count and cannot also be full
  `SLE_ASSERT_SAME(a_empty, done_o && is_empty_o, (count_o == '0) && !is_full_o)
  // rejected insert only when the store is full
  `SLE_ASSERT_SAME(a_full, done_o && (status_o == sle_pkg::STATUS_FULL), is_full_o)
  // a failed delete never reports a match
  `SLE_ASSERT_SAME(a_miss, done_o && (status_o == sle_pkg::STATUS_NOT_FOUND), !found_o)

endmodule

bind sorted_list_engine sle_checker u_sle_checker (.*);
